// ===== src/assert_macros.svh =====
// Assertion macros shared by the ring unit RTL.
// No dependencies; define NO_ASSERTIONS to compile them out.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define CRL_ASSERT_IMPLIES(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("ring unit assertion failed");
`define CRL_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("ring unit assertion failed");
`else
`define CRL_ASSERT_IMPLIES(label, clk, rst, ante, cons)
`define CRL_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

// ===== src/crl_pkg.sv =====
// Package for the circular doubly linked ring unit: sizes, codes, types.
// No dependencies; used by crl_divu, the top level and the bench.
package crl_pkg;

   localparam int DEPTH      = 256;
   localparam int ADDR_W     = $clog2(DEPTH);
   localparam int CNT_W      = $clog2(DEPTH + 1);
   localparam int DATA_W     = 32;
   localparam int STEP_W     = 32;
   localparam int STEP_IDX_W = $clog2(STEP_W);

   localparam int REQ_FIELDS_W = DATA_W + 1 + STEP_W;
   localparam int REQ_TDATA_W  = ((REQ_FIELDS_W + 7) / 8) * 8;
   localparam int RSP_FIELDS_W = DATA_W + CNT_W;
   localparam int RSP_TDATA_W  = ((RSP_FIELDS_W + 7) / 8) * 8;
   localparam int RSP_PAD_W    = RSP_TDATA_W - RSP_FIELDS_W;

   typedef logic [1:0] mode_type;
   typedef logic [1:0] status_type;

   localparam mode_type MODE_PUSH   = 2'd0;
   localparam mode_type MODE_POP    = 2'd1;
   localparam mode_type MODE_PEEK   = 2'd2;
   localparam mode_type MODE_ROTATE = 2'd3;

   localparam status_type STATUS_OK    = 2'd0;
   localparam status_type STATUS_EMPTY = 2'd1;
   localparam status_type STATUS_FULL  = 2'd2;

   typedef struct packed {
      logic             done;
      logic [CNT_W-1:0] remainder;
   } div_res_type;

endpackage

// ===== src/crl_ram.sv =====
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
module crl_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== src/crl_divu.sv =====
// Bit-serial remainder unit: dividend mod divisor, one quotient bit per cycle.
// Depends on crl_pkg.
module crl_divu (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start,
   input  logic [crl_pkg::STEP_W-1:0] dividend,
   input  logic [crl_pkg::CNT_W-1:0]  divisor,
   output crl_pkg::div_res_type       result
);
   import crl_pkg::*;

   logic                  busy_ff, busy_in;
   logic                  done_ff, done_in;
   logic [STEP_IDX_W-1:0] idx_ff, idx_in;
   logic [STEP_W-1:0]     quo_ff, quo_in;
   logic [CNT_W-1:0]      rem_ff, rem_in;
   logic [CNT_W-1:0]      dvs_ff, dvs_in;
   logic [CNT_W:0]        trial;
   logic [CNT_W:0]        diff;

   always_comb begin
      trial   = {rem_ff, quo_ff[STEP_W-1]};
      diff    = trial - {1'b0, dvs_ff};
      busy_in = busy_ff;
      done_in = 1'b0;
      idx_in  = idx_ff;
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      if (start) begin
         busy_in = 1'b1;
         idx_in  = '0;
         quo_in  = dividend;
         rem_in  = '0;
         dvs_in  = divisor;
      end else if (busy_ff) begin
         quo_in = {quo_ff[STEP_W-2:0], 1'b0};
         // remainder stays below the divisor, so trial fits one extra bit
         rem_in = (trial >= {1'b0, dvs_ff}) ? diff[CNT_W-1:0] : trial[CNT_W-1:0];
         idx_in = idx_ff + 1'b1;
         if (idx_ff == STEP_IDX_W'(STEP_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      idx_ff <= idx_in;
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
   end

   assign result.done      = done_ff;
   assign result.remainder = rem_ff;

endmodule

// ===== src/circular_doubly_linked_ring_unit.sv =====
// Top level of the circular doubly linked ring: sequencer around four RAMs.
// Depends on crl_pkg, crl_ram, crl_divu and assert_macros.svh.
//
//  channel  dir  fields (low bit first)
//  req      in   tuser: mode | tdata: value_in, direction, steps
//  rsp      out  tuser: status | tdata: value_out, entries
//
// A request is taken in the idle state and passes the look state. A push
// into a ring neither empty nor full then passes the link state; a rotate on
// a non-empty ring runs the serial remainder unit, then a RAM read and a walk
// state per link walked. The rsp register loads in the done state. Reset is
// synchronous; the RAMs need no clearing. A stalled rsp holds the next result
// in the sequencer; one more request is taken while a result waits.
`include "assert_macros.svh"
module circular_doubly_linked_ring_unit (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   input  logic [crl_pkg::REQ_TDATA_W-1:0] req_tdata, // value_in, direction, steps
   input  logic [1:0]                      req_tuser, // mode
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   output logic [crl_pkg::RSP_TDATA_W-1:0] rsp_tdata, // value_out, entries
   output logic [1:0]                      rsp_tuser  // status
);
   import crl_pkg::*;

   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_LOOK  = 3'd1;
   localparam logic [2:0] S_LINK  = 3'd2;
   localparam logic [2:0] S_DIV   = 3'd3;
   localparam logic [2:0] S_WRD   = 3'd4;
   localparam logic [2:0] S_WWT   = 3'd5;
   localparam logic [2:0] S_DONE  = 3'd6;

   logic [2:0]        state_ff, state_in;
   mode_type          mode_ff, mode_in;
   logic [DATA_W-1:0] val_ff, val_in;
   logic              dir_ff, dir_in;
   logic [STEP_W-1:0] steps_ff, steps_in;
   logic [ADDR_W-1:0] head_ff, head_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic [ADDR_W-1:0] left_ff, left_in;
   logic [ADDR_W-1:0] right_ff, right_in;
   logic [ADDR_W-1:0] slot_ff, slot_in;
   logic [CNT_W-1:0]  walk_ff, walk_in;
   logic [DATA_W-1:0] res_value_ff, res_value_in;
   status_type        res_status_ff, res_status_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [DATA_W-1:0] rsp_value_ff, rsp_value_in;
   status_type        rsp_status_ff, rsp_status_in;
   logic [CNT_W-1:0]  rsp_entries_ff, rsp_entries_in;
   logic [DEPTH-1:0]  free_vld_ff, free_vld_in;
   logic              fvld_rd_ff;
   logic [ADDR_W-1:0] top_rd_ff;

   logic              nxt_we, prv_we, val_we, free_we;
   logic [ADDR_W-1:0] nxt_wa, nxt_wd, prv_wa, prv_wd, val_wa, free_wa, free_wd;
   logic [DATA_W-1:0] val_wd;
   logic [ADDR_W-1:0] nx_rd, tl_rd, free_rd, top_addr, fs;
   logic [DATA_W-1:0] hv_rd;
   logic              req_xfer, rsp_xfer, div_start;
   div_res_type       div_res;

   assign req_tready = (state_ff == S_IDLE);
   assign req_xfer   = req_tvalid && req_tready;
   assign rsp_xfer   = rsp_valid_ff && rsp_tready;

   // top of the free stack: DEPTH - count - 1
   assign top_addr = ADDR_W'(CNT_W'(DEPTH - 1) - count_ff);
   assign fs       = fvld_rd_ff ? free_rd : top_rd_ff;

   crl_ram #(.WIDTH(ADDR_W), .DEPTH(DEPTH)) u_next_ram (
      .clock(clock), .wr_en(nxt_we), .wr_addr(nxt_wa), .wr_data(nxt_wd),
      .rd_addr(head_ff), .rd_data(nx_rd));

   crl_ram #(.WIDTH(ADDR_W), .DEPTH(DEPTH)) u_prev_ram (
      .clock(clock), .wr_en(prv_we), .wr_addr(prv_wa), .wr_data(prv_wd),
      .rd_addr(head_ff), .rd_data(tl_rd));

   crl_ram #(.WIDTH(DATA_W), .DEPTH(DEPTH)) u_value_ram (
      .clock(clock), .wr_en(val_we), .wr_addr(val_wa), .wr_data(val_wd),
      .rd_addr(head_ff), .rd_data(hv_rd));

   crl_ram #(.WIDTH(ADDR_W), .DEPTH(DEPTH)) u_free_ram (
      .clock(clock), .wr_en(free_we), .wr_addr(free_wa), .wr_data(free_wd),
      .rd_addr(top_addr), .rd_data(free_rd));

   crl_divu u_divu (
      .clock(clock), .reset(reset), .start(div_start),
      .dividend(steps_ff), .divisor(count_ff), .result(div_res));

   always_comb begin
      state_in       = state_ff;
      mode_in        = mode_ff;
      val_in         = val_ff;
      dir_in         = dir_ff;
      steps_in       = steps_ff;
      head_in        = head_ff;
      count_in       = count_ff;
      left_in        = left_ff;
      right_in       = right_ff;
      slot_in        = slot_ff;
      walk_in        = walk_ff;
      res_value_in   = res_value_ff;
      res_status_in  = res_status_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_tready;
      rsp_value_in   = rsp_value_ff;
      rsp_status_in  = rsp_status_ff;
      rsp_entries_in = rsp_entries_ff;
      free_vld_in    = free_vld_ff;
      nxt_we  = 1'b0;
      nxt_wa  = '0;
      nxt_wd  = '0;
      prv_we  = 1'b0;
      prv_wa  = '0;
      prv_wd  = '0;
      val_we  = 1'b0;
      val_wa  = '0;
      val_wd  = '0;
      free_we = 1'b0;
      free_wa = '0;
      free_wd = '0;
      div_start = 1'b0;

      case (state_ff)
         S_IDLE: begin
            if (req_xfer) begin
               mode_in  = req_tuser;
               val_in   = req_tdata[DATA_W-1:0];
               dir_in   = req_tdata[DATA_W];
               steps_in = req_tdata[DATA_W+STEP_W:DATA_W+1];
               state_in = S_LOOK;
            end
         end
         S_LOOK: begin
            res_value_in  = '0;
            res_status_in = STATUS_OK;
            state_in      = S_DONE;
            case (mode_ff)
               MODE_PUSH: begin
                  if (count_ff == CNT_W'(DEPTH)) begin
                     res_status_in = STATUS_FULL;
                  end else begin
                     val_we   = 1'b1;
                     val_wa   = fs;
                     val_wd   = val_ff;
                     count_in = count_ff + 1'b1;
                     if (count_ff == '0) begin
                        // first value links to itself
                        head_in = fs;
                        nxt_we  = 1'b1;
                        nxt_wa  = fs;
                        nxt_wd  = fs;
                        prv_we  = 1'b1;
                        prv_wa  = fs;
                        prv_wd  = fs;
                     end else begin
                        // new slot goes between left and right
                        left_in  = dir_ff ? tl_rd : head_ff;
                        right_in = dir_ff ? head_ff : nx_rd;
                        slot_in  = fs;
                        nxt_we   = 1'b1;
                        nxt_wa   = dir_ff ? tl_rd : head_ff;
                        nxt_wd   = fs;
                        prv_we   = 1'b1;
                        prv_wa   = dir_ff ? head_ff : nx_rd;
                        prv_wd   = fs;
                        state_in = S_LINK;
                     end
                  end
               end
               MODE_POP, MODE_PEEK: begin
                  if (count_ff == '0) begin
                     res_status_in = STATUS_EMPTY;
                  end else begin
                     res_value_in = hv_rd;
                     if (mode_ff == MODE_POP) begin
                        if (count_ff > CNT_W'(1)) begin
                           nxt_we  = 1'b1;
                           nxt_wa  = tl_rd;
                           nxt_wd  = nx_rd;
                           prv_we  = 1'b1;
                           prv_wa  = nx_rd;
                           prv_wd  = tl_rd;
                           head_in = dir_ff ? tl_rd : nx_rd;
                        end
                        count_in = count_ff - 1'b1;
                        // slot returns to the stack top after the decrement
                        free_we  = 1'b1;
                        free_wa  = ADDR_W'(CNT_W'(DEPTH) - count_ff);
                        free_wd  = head_ff;
                        free_vld_in[ADDR_W'(CNT_W'(DEPTH) - count_ff)] = 1'b1;
                     end
                  end
               end
               MODE_ROTATE: begin
                  if (count_ff != '0) begin
                     div_start = 1'b1;
                     state_in  = S_DIV;
                  end
               end
               default: begin
                  state_in = S_DONE;
               end
            endcase
         end
         S_LINK: begin
            nxt_we   = 1'b1;
            nxt_wa   = slot_ff;
            nxt_wd   = right_ff;
            prv_we   = 1'b1;
            prv_wa   = slot_ff;
            prv_wd   = left_ff;
            state_in = S_DONE;
         end
         S_DIV: begin
            if (div_res.done) begin
               walk_in  = div_res.remainder;
               state_in = S_WRD;
            end
         end
         S_WRD: begin
            // link RAMs read at head during this cycle
            state_in = (walk_ff == '0) ? S_DONE : S_WWT;
         end
         S_WWT: begin
            head_in  = dir_ff ? tl_rd : nx_rd;
            walk_in  = walk_ff - 1'b1;
            state_in = S_WRD;
         end
         S_DONE: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in   = 1'b1;
               rsp_value_in   = res_value_ff;
               rsp_status_in  = res_status_ff;
               rsp_entries_in = count_ff;
               state_in       = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         head_ff      <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
         free_vld_ff  <= '0;
      end else begin
         state_ff     <= state_in;
         head_ff      <= head_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
         free_vld_ff  <= free_vld_in;
      end
      mode_ff        <= mode_in;
      val_ff         <= val_in;
      dir_ff         <= dir_in;
      steps_ff       <= steps_in;
      left_ff        <= left_in;
      right_ff       <= right_in;
      slot_ff        <= slot_in;
      walk_ff        <= walk_in;
      res_value_ff   <= res_value_in;
      res_status_ff  <= res_status_in;
      rsp_value_ff   <= rsp_value_in;
      rsp_status_ff  <= rsp_status_in;
      rsp_entries_ff <= rsp_entries_in;
      // never-written stack entries read as their own index
      fvld_rd_ff     <= free_vld_ff[top_addr];
      top_rd_ff      <= top_addr;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{RSP_PAD_W{1'b0}}, rsp_entries_ff, rsp_value_ff};
   assign rsp_tuser  = rsp_status_ff;

   `CRL_ASSERT_IMPLIES(a_count_range, clock, reset, 1'b1, count_ff <= CNT_W'(DEPTH))
   `CRL_ASSERT_IMPLIES(a_full_entries, clock, reset,
      rsp_valid_ff && (rsp_status_ff == STATUS_FULL), rsp_entries_ff == CNT_W'(DEPTH))
   `CRL_ASSERT_IMPLIES(a_empty_entries, clock, reset,
      rsp_valid_ff && (rsp_status_ff == STATUS_EMPTY), rsp_entries_ff == '0)
   `CRL_ASSERT_IMPLIES(a_div_done_state, clock, reset, div_res.done, state_ff == S_DIV)
   `CRL_ASSERT_IMPLIES(a_walk_nonempty, clock, reset, state_ff == S_WWT, count_ff != '0)

endmodule

// ===== tb/tb_circular_doubly_linked_ring_unit.sv =====
// Self-checking bench for circular_doubly_linked_ring_unit: directed and random ring operations.
// A local ring model predicts each response. Depends on crl_pkg and the RTL of the unit.
module tb_circular_doubly_linked_ring_unit;
   import crl_pkg::*;

   typedef struct {
      mode_type          mode;
      logic [DATA_W-1:0] value;
      logic              dir;
      logic [STEP_W-1:0] steps;
      bit                drain;   // hold back until all responses are in
   } ring_req_type;

   typedef struct {
      logic [DATA_W-1:0] value;
      status_type        status;
      logic [CNT_W-1:0]  entries;
   } ring_rsp_type;

   logic                   clock = 1'b0;
   logic                   reset;
   logic                   req_tvalid;
   logic                   req_tready;
   logic [REQ_TDATA_W-1:0] req_tdata;  // value_in, direction, steps
   logic [1:0]             req_tuser;  // mode
   logic                   rsp_tvalid;
   logic                   rsp_tready;
   logic [RSP_TDATA_W-1:0] rsp_tdata;  // value_out, entries
   logic [1:0]             rsp_tuser;  // status

   circular_doubly_linked_ring_unit dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   always #5 clock = ~clock;

   // ring model state
   logic [DATA_W-1:0] ring_value [DEPTH];
   logic [ADDR_W-1:0] ring_next  [DEPTH];
   logic [ADDR_W-1:0] ring_prev  [DEPTH];
   logic [ADDR_W-1:0] free_stack [DEPTH];
   logic [ADDR_W-1:0] ring_head;
   int                ring_count;

   ring_req_type req_backlog[$];
   ring_rsp_type due_results[$];
   ring_req_type offer;
   ring_rsp_type want;
   bit        req_taken;
   int        accepted_count;
   int        error_count;
   int        gen_count;
   int        random_added;
   int        hold_left;
   bit        hold_done;

   function automatic ring_rsp_type ring_apply(ring_req_type it);
      ring_rsp_type      r;
      logic [ADDR_W-1:0] s, h, nx, tl;
      int unsigned       n;
      r.value  = '0;
      r.status = STATUS_OK;
      case (it.mode)
         MODE_PUSH: begin
            if (ring_count >= DEPTH) begin
               r.status = STATUS_FULL;
            end else begin
               s = free_stack[DEPTH - ring_count - 1];
               ring_value[s] = it.value;
               if (ring_count == 0) begin
                  ring_head = s;
                  ring_next[s] = s;
                  ring_prev[s] = s;
               end else if (!it.dir) begin
                  h = ring_head;
                  nx = ring_next[h];
                  ring_next[s] = nx;
                  ring_prev[nx] = s;
                  ring_next[h] = s;
                  ring_prev[s] = h;
               end else begin
                  h = ring_head;
                  tl = ring_prev[h];
                  ring_next[tl] = s;
                  ring_prev[s] = tl;
                  ring_next[s] = h;
                  ring_prev[h] = s;
               end
               ring_count++;
            end
         end
         MODE_POP, MODE_PEEK: begin
            if (ring_count == 0) begin
               r.status = STATUS_EMPTY;
            end else begin
               h = ring_head;
               r.value = ring_value[h];
               if (it.mode == MODE_POP) begin
                  if (ring_count > 1) begin
                     tl = ring_prev[h];
                     nx = ring_next[h];
                     ring_next[tl] = nx;
                     ring_prev[nx] = tl;
                     ring_head = it.dir ? tl : nx;
                  end
                  ring_count--;
                  free_stack[DEPTH - ring_count - 1] = h;
               end
            end
         end
         default: begin
            if (ring_count != 0) begin
               n = it.steps % ring_count;
               h = ring_head;
               for (int k = 0; k < n; k++)
                  h = it.dir ? ring_prev[h] : ring_next[h];
               ring_head = h;
            end
         end
      endcase
      r.entries = CNT_W'(ring_count);
      return r;
   endfunction

   function automatic int sender_idle_pct();
      case ((accepted_count / 100) % 4)
         1:       return 85;
         3:       return 33;
         default: return 0;
      endcase
   endfunction

   function automatic int receiver_stall_pct();
      case ((accepted_count / 100) % 4)
         2:       return 85;
         3:       return 33;
         default: return 0;
      endcase
   endfunction

   function automatic logic [STEP_W-1:0] pick_steps(int count);
      case ($urandom_range(4))
         0:       return STEP_W'($urandom_range(5));
         1:       return STEP_W'(count * $urandom_range(3));
         default: return $urandom();
      endcase
   endfunction

   task automatic add_item(mode_type mode, logic [DATA_W-1:0] value, logic dir,
                           logic [STEP_W-1:0] steps, bit drain);
      ring_req_type it;
      it.mode  = mode;
      it.value = value;
      it.dir   = dir;
      it.steps = steps;
      it.drain = drain;
      req_backlog.push_back(it);
      // occupancy only, to steer the random mix
      if (mode == MODE_PUSH && gen_count < DEPTH)
         gen_count++;
      else if (mode == MODE_POP && gen_count > 0)
         gen_count--;
   endtask

   task automatic add_random(int push_pct, int pop_pct, bit drain);
      int       roll;
      mode_type mode;
      roll = $urandom_range(99);
      if (roll < push_pct)
         mode = MODE_PUSH;
      else if (roll < push_pct + pop_pct)
         mode = MODE_POP;
      else if (roll < push_pct + pop_pct + (100 - push_pct - pop_pct) / 2)
         mode = MODE_PEEK;
      else
         mode = MODE_ROTATE;
      add_item(mode, $urandom(), 1'($urandom_range(1)),
               mode == MODE_ROTATE ? pick_steps(gen_count) : $urandom(), drain);
      random_added++;
   endtask

   // request driver
   always @(negedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else if (!req_tvalid || req_taken) begin
         req_taken = 1'b0;
         if (req_backlog.size() != 0 && $urandom_range(99) >= sender_idle_pct()
             && !(req_backlog[0].drain && due_results.size() != 0)) begin
            offer = req_backlog.pop_front();
            req_tuser  <= offer.mode;
            req_tdata  <= REQ_TDATA_W'({offer.steps, offer.dir, offer.value});
            req_tvalid <= 1'b1;
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // response ready, with one long hold-off
   always @(negedge clock) begin
      if (reset)
         rsp_tready <= 1'b0;
      else
         rsp_tready <= (hold_left == 0) && ($urandom_range(99) >= receiver_stall_pct());
   end

   always @(negedge clock) begin
      if (!reset && !hold_done && accepted_count >= 410) begin
         hold_left <= 400;
         hold_done <= 1'b1;
      end else if (hold_left != 0) begin
         hold_left <= hold_left - 1;
      end
   end

   // monitor and checker
   always @(posedge clock) begin
      if (!reset) begin
         if (req_tvalid && req_tready) begin
            due_results.push_back(ring_apply(offer));
            accepted_count++;
            req_taken = 1'b1;
         end
         if (rsp_tvalid && rsp_tready) begin
            if (due_results.size() == 0) begin
               $display("%0t: unexpected transfer: value %h status %0d entries %0d",
                        $time, rsp_tdata[DATA_W-1:0], rsp_tuser,
                        rsp_tdata[DATA_W +: CNT_W]);
               error_count++;
            end else begin
               want = due_results.pop_front();
               if (rsp_tdata[DATA_W-1:0] !== want.value) begin
                  $display("%0t: value_out expected %h actual %h",
                           $time, want.value, rsp_tdata[DATA_W-1:0]);
                  error_count++;
               end
               if (rsp_tuser !== want.status) begin
                  $display("%0t: status expected %0d actual %0d",
                           $time, want.status, rsp_tuser);
                  error_count++;
               end
               if (rsp_tdata[DATA_W +: CNT_W] !== want.entries) begin
                  $display("%0t: entries expected %0d actual %0d",
                           $time, want.entries, rsp_tdata[DATA_W +: CNT_W]);
                  error_count++;
               end
            end
         end
      end
   end

   initial begin
      #30_000_000;
      $display("DONE: errors detected");
      $finish;
   end

   initial begin
      int kind;
      int len;
      bit full_done;
      reset          = 1'b1;
      req_tvalid     = 1'b0;
      req_tdata      = '0;
      req_tuser      = MODE_PUSH;
      rsp_tready     = 1'b0;
      req_taken      = 1'b0;
      accepted_count = 0;
      error_count    = 0;
      gen_count      = 0;
      random_added   = 0;
      hold_left      = 0;
      hold_done      = 1'b0;
      ring_head      = '0;
      ring_count     = 0;
      full_done      = 1'b0;
      for (int k = 0; k < DEPTH; k++)
         free_stack[k] = ADDR_W'(k);

      // directed: empty ring, extremes, both directions, last pop, stale head
      add_item(MODE_PEEK,   $urandom(),     1'b0, $urandom(),      1'b0);
      add_item(MODE_POP,    $urandom(),     1'b1, $urandom(),      1'b0);
      add_item(MODE_ROTATE, $urandom(),     1'b0, 32'hFFFF_FFFF,   1'b0);
      add_item(MODE_PUSH,   32'h7FFF_FFFF,  1'b1, $urandom(),      1'b0);
      add_item(MODE_PUSH,   32'h8000_0000,  1'b0, $urandom(),      1'b0);
      add_item(MODE_PUSH,   32'h0000_0000,  1'b1, $urandom(),      1'b0);
      add_item(MODE_PUSH,   32'hFFFF_FFFF,  1'b0, $urandom(),      1'b0);
      add_item(MODE_PEEK,   $urandom(),     1'b1, $urandom(),      1'b0);
      add_item(MODE_ROTATE, $urandom(),     1'b0, 32'd0,           1'b0);
      add_item(MODE_ROTATE, $urandom(),     1'b1, 32'd4,           1'b0);
      add_item(MODE_ROTATE, $urandom(),     1'b0, 32'd1,           1'b0);
      add_item(MODE_ROTATE, $urandom(),     1'b1, 32'hFFFF_FFFF,   1'b0);
      add_item(MODE_ROTATE, $urandom(),     1'b0, 32'd6,           1'b0);
      add_item(MODE_POP,    $urandom(),     1'b0, $urandom(),      1'b0);
      add_item(MODE_POP,    $urandom(),     1'b1, $urandom(),      1'b0);
      add_item(MODE_PEEK,   $urandom(),     1'b0, $urandom(),      1'b0);
      add_item(MODE_POP,    $urandom(),     1'b0, $urandom(),      1'b0);
      add_item(MODE_POP,    $urandom(),     1'b1, $urandom(),      1'b0);
      add_item(MODE_POP,    $urandom(),     1'b0, $urandom(),      1'b0);
      add_item(MODE_PUSH,   32'd5,          1'b1, $urandom(),      1'b0);
      add_item(MODE_PUSH,   32'hAAAA_AAAA,  1'b1, $urandom(),      1'b0);
      add_item(MODE_PUSH,   32'h5555_5555,  1'b0, $urandom(),      1'b0);
      add_item(MODE_ROTATE, $urandom(),     1'b1, 32'd2,           1'b0);
      add_item(MODE_POP,    $urandom(),     1'b1, $urandom(),      1'b0);

      // random: fill-heavy, drain-heavy and balanced runs, one run up to full
      add_random(40, 20, 1'b1);
      while (random_added < 900) begin
         if (!full_done && random_added >= 300) begin
            add_item(MODE_PEEK, $urandom(), 1'($urandom_range(1)), $urandom(), 1'b1);
            // peek, fill pushes, three refused pushes, rotate and peek
            random_added += DEPTH - gen_count + 6;
            while (gen_count < DEPTH)
               add_item(MODE_PUSH, $urandom(), 1'($urandom_range(1)), $urandom(), 1'b0);
            repeat (3)
               add_item(MODE_PUSH, $urandom(), 1'($urandom_range(1)), $urandom(), 1'b0);
            add_item(MODE_ROTATE, $urandom(), 1'($urandom_range(1)), $urandom(), 1'b0);
            add_item(MODE_PEEK, $urandom(), 1'($urandom_range(1)), $urandom(), 1'b0);
            full_done = 1'b1;
         end else begin
            kind = $urandom_range(2);
            len  = $urandom_range(20, 60);
            repeat (len) begin
               case (kind)
                  0:       add_random(70, 15, 1'b0);
                  1:       add_random(15, 65, 1'b0);
                  default: add_random(35, 30, 1'b0);
               endcase
            end
         end
      end

      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      while (req_backlog.size() != 0 || req_tvalid || due_results.size() != 0)
         @(posedge clock);
      repeat (600) @(posedge clock);
      if (error_count == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end

endmodule
